FILE: hdl/gru_pkg.sv
// gru_pkg: widths, datapath operation codes and status type of the givens rotation unit
// shared by the controller, the datapath and the top level; no dependencies
package gru_pkg;

   localparam int DW       = 32;                      // data width, Q16.16 at 32
   localparam int OPW      = (DW + 1 > 32) ? DW + 1 : 32;  // multiplier operand width
   localparam int PW       = 2 * OPW;                 // product width
   localparam int AW       = PW + 1;                  // accumulator width
   localparam int TW       = AW - 30;                 // rounded apply value width
   localparam int RW       = DW + 3;                  // square root remainder width
   localparam int QW       = 32;                      // ratio quotient bits
   localparam int CW       = $clog2(((DW > QW) ? DW : QW) + 1);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_AA,
      OP_MUL_BB,
      OP_MUL_CX,
      OP_MUL_SY,
      OP_MUL_CY,
      OP_MUL_SX,
      OP_ACC_LOAD,
      OP_ACC_ADD,
      OP_ACC_SUB,
      OP_RND1,
      OP_RND2,
      OP_RT_INIT,
      OP_RT_STEP,
      OP_RT_RND,
      OP_DV_INIT_C,
      OP_DV_INIT_S,
      OP_DV_STEP,
      OP_DV_END_C,
      OP_DV_END_S,
      OP_GEN_RES,
      OP_ZERO,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic apply;
      logic zero;
   } status_type;

endpackage

FILE: hdl/gru_datapath.sv
// gru_datapath: shared multiplier, accumulator, bit-serial square root and divider
// depends on gru_pkg; driven one operation a cycle by gru_ctrl
module gru_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  gru_pkg::dp_op_type       op,
   input  logic                     in_opcode,
   input  logic [gru_pkg::DW-1:0]   in_first,
   input  logic [gru_pkg::DW-1:0]   in_second,
   output gru_pkg::status_type      status,
   output logic [gru_pkg::DW-1:0]   out_first,
   output logic [gru_pkg::DW-1:0]   out_second
);

   localparam int DW  = gru_pkg::DW;
   localparam int OPW = gru_pkg::OPW;
   localparam int PW  = gru_pkg::PW;
   localparam int AW  = gru_pkg::AW;
   localparam int TW  = gru_pkg::TW;
   localparam int RW  = gru_pkg::RW;
   localparam int QW  = gru_pkg::QW;

   localparam logic signed [AW-1:0] RHALF = AW'(64'd1 << 29);
   localparam logic signed [TW-1:0] TMAX  = TW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [TW-1:0] TMIN  = -TMAX - TW'(1);
   localparam logic [DW:0]          RMAX  = {2'b00, {(DW-1){1'b1}}};

   logic                   opc_ff;
   logic signed [DW-1:0]   x_ff, y_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [AW-1:0]   acc_ff;
   logic [2*DW-1:0]        rad_ff;
   logic [RW-1:0]          rem_ff;
   logic [DW:0]            root_ff;
   logic [DW+1:0]          drem_ff;
   logic [QW-1:0]          dq_ff;
   logic signed [31:0]     cos_ff, sin_ff;
   logic [DW-1:0]          res1_ff, res2_ff;
   logic [DW-1:0]          first_ff, second_ff;

   logic [DW-1:0]          ax, ay;
   logic signed [OPW-1:0]  mul_a, mul_b;
   logic signed [AW-1:0]   rsum;
   logic signed [TW-1:0]   rt;
   logic [DW-1:0]          rsat;
   logic [RW-1:0]          remsh, trial;
   logic                   rt_ge;
   logic                   dv_ge;
   logic [DW+1:0]          dsub;
   logic [QW:0]            qinc;
   logic [31:0]            qmag;

   assign ax = x_ff[DW-1] ? (~x_ff + 1'b1) : x_ff;
   assign ay = y_ff[DW-1] ? (~y_ff + 1'b1) : y_ff;

   assign status.apply = opc_ff;
   assign status.zero  = (x_ff == '0) && (y_ff == '0);

   always_comb begin
      mul_a = OPW'(ax);
      mul_b = OPW'(ax);
      case (op)
         gru_pkg::OP_MUL_BB: begin
            mul_a = OPW'(ay);
            mul_b = OPW'(ay);
         end
         gru_pkg::OP_MUL_CX: begin
            mul_a = OPW'(cos_ff);
            mul_b = OPW'(x_ff);
         end
         gru_pkg::OP_MUL_SY: begin
            mul_a = OPW'(sin_ff);
            mul_b = OPW'(y_ff);
         end
         gru_pkg::OP_MUL_CY: begin
            mul_a = OPW'(cos_ff);
            mul_b = OPW'(y_ff);
         end
         gru_pkg::OP_MUL_SX: begin
            mul_a = OPW'(sin_ff);
            mul_b = OPW'(x_ff);
         end
         default: begin
            mul_a = OPW'(ax);
            mul_b = OPW'(ax);
         end
      endcase
   end

   // round half up then saturate
   assign rsum = acc_ff + RHALF;
   assign rt   = TW'(rsum >>> 30);
   assign rsat = (rt > TMAX) ? DW'(TMAX) : ((rt < TMIN) ? DW'(TMIN) : DW'(rt));

   // square root digit step
   assign remsh = {rem_ff[RW-3:0], rad_ff[2*DW-1:2*DW-2]};
   assign trial = {root_ff, 2'b01};
   assign rt_ge = (remsh >= trial);

   // divider step
   assign dv_ge = (drem_ff >= {1'b0, root_ff});
   assign dsub  = dv_ge ? (drem_ff - {1'b0, root_ff}) : drem_ff;
   assign qinc  = {1'b0, dq_ff} + (QW+1)'(1);
   assign qmag  = qinc[QW:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= '0;
         sin_ff <= '0;
      end else begin
         case (op)
            gru_pkg::OP_DV_END_C: cos_ff <= x_ff[DW-1] ? -$signed(qmag) : $signed(qmag);
            gru_pkg::OP_DV_END_S: sin_ff <= y_ff[DW-1] ? -$signed(qmag) : $signed(qmag);
            gru_pkg::OP_ZERO: begin
               cos_ff <= '0;
               sin_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         gru_pkg::OP_LOAD: begin
            opc_ff <= in_opcode;
            x_ff   <= in_first;
            y_ff   <= in_second;
         end
         gru_pkg::OP_MUL_AA, gru_pkg::OP_MUL_BB, gru_pkg::OP_MUL_CX,
         gru_pkg::OP_MUL_SY, gru_pkg::OP_MUL_CY, gru_pkg::OP_MUL_SX: begin
            prod_ff <= mul_a * mul_b;
         end
         gru_pkg::OP_ACC_LOAD: acc_ff <= AW'(prod_ff);
         gru_pkg::OP_ACC_ADD:  acc_ff <= acc_ff + AW'(prod_ff);
         gru_pkg::OP_ACC_SUB:  acc_ff <= acc_ff - AW'(prod_ff);
         gru_pkg::OP_RND1:     res1_ff <= rsat;
         gru_pkg::OP_RND2:     res2_ff <= rsat;
         gru_pkg::OP_RT_INIT: begin
            rad_ff  <= acc_ff[2*DW-1:0];
            rem_ff  <= '0;
            root_ff <= '0;
         end
         gru_pkg::OP_RT_STEP: begin
            rad_ff  <= {rad_ff[2*DW-3:0], 2'b00};
            rem_ff  <= rt_ge ? (remsh - trial) : remsh;
            root_ff <= {root_ff[DW-1:0], rt_ge};
         end
         gru_pkg::OP_RT_RND: begin
            if (rem_ff > RW'(root_ff)) begin
               root_ff <= root_ff + (DW+1)'(1);
            end
         end
         gru_pkg::OP_DV_INIT_C: begin
            drem_ff <= (DW+2)'(ax);
            dq_ff   <= '0;
         end
         gru_pkg::OP_DV_INIT_S: begin
            drem_ff <= (DW+2)'(ay);
            dq_ff   <= '0;
         end
         gru_pkg::OP_DV_STEP: begin
            drem_ff <= {dsub[DW:0], 1'b0};
            dq_ff   <= {dq_ff[QW-2:0], dv_ge};
         end
         gru_pkg::OP_GEN_RES: begin
            res1_ff <= (root_ff > RMAX) ? RMAX[DW-1:0] : root_ff[DW-1:0];
            res2_ff <= '0;
         end
         gru_pkg::OP_ZERO: begin
            res1_ff <= '0;
            res2_ff <= '0;
         end
         gru_pkg::OP_OUT: begin
            first_ff  <= res1_ff;
            second_ff <= res2_ff;
         end
         default: ;
      endcase
   end

   assign out_first  = first_ff;
   assign out_second = second_ff;

endmodule

FILE: hdl/gru_ctrl.sv
// gru_ctrl: sequencer of the givens rotation unit, handshakes and step counting
// depends on gru_pkg; issues one datapath operation a cycle to gru_datapath
module gru_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  gru_pkg::status_type   status,
   output gru_pkg::dp_op_type    op
);

   localparam int CW = gru_pkg::CW;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_ZERO,
      S_MAA, S_ALDG, S_MBB, S_AADG,
      S_RTINIT, S_RTSTEP, S_RTRND,
      S_DVINC, S_DVSTC, S_DVENC, S_DVINS, S_DVSTS, S_DVENS, S_GENRES,
      S_MCX, S_ALD1, S_MSY, S_AADD, S_RND1,
      S_MCY, S_ALD2, S_MSX, S_ASUB, S_RND2,
      S_OUT
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         S_IDLE:   op = req_valid ? gru_pkg::OP_LOAD : gru_pkg::OP_NONE;
         S_ZERO:   op = gru_pkg::OP_ZERO;
         S_MAA:    op = gru_pkg::OP_MUL_AA;
         S_MBB:    op = gru_pkg::OP_MUL_BB;
         S_ALDG, S_ALD1, S_ALD2: op = gru_pkg::OP_ACC_LOAD;
         S_AADG, S_AADD:         op = gru_pkg::OP_ACC_ADD;
         S_ASUB:   op = gru_pkg::OP_ACC_SUB;
         S_RTINIT: op = gru_pkg::OP_RT_INIT;
         S_RTSTEP: op = gru_pkg::OP_RT_STEP;
         S_RTRND:  op = gru_pkg::OP_RT_RND;
         S_DVINC:  op = gru_pkg::OP_DV_INIT_C;
         S_DVINS:  op = gru_pkg::OP_DV_INIT_S;
         S_DVSTC, S_DVSTS: op = gru_pkg::OP_DV_STEP;
         S_DVENC:  op = gru_pkg::OP_DV_END_C;
         S_DVENS:  op = gru_pkg::OP_DV_END_S;
         S_GENRES: op = gru_pkg::OP_GEN_RES;
         S_MCX:    op = gru_pkg::OP_MUL_CX;
         S_MSY:    op = gru_pkg::OP_MUL_SY;
         S_MCY:    op = gru_pkg::OP_MUL_CY;
         S_MSX:    op = gru_pkg::OP_MUL_SX;
         S_RND1:   op = gru_pkg::OP_RND1;
         S_RND2:   op = gru_pkg::OP_RND2;
         S_OUT:    op = out_free ? gru_pkg::OP_OUT : gru_pkg::OP_NONE;
         default:  op = gru_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (status.apply) begin
                  state_ff <= S_MCX;
               end else if (status.zero) begin
                  state_ff <= S_ZERO;
               end else begin
                  state_ff <= S_MAA;
               end
            end
            S_ZERO:   state_ff <= S_OUT;
            S_MAA:    state_ff <= S_ALDG;
            S_ALDG:   state_ff <= S_MBB;
            S_MBB:    state_ff <= S_AADG;
            S_AADG:   state_ff <= S_RTINIT;
            S_RTINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_RTSTEP;
            end
            S_RTSTEP: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(gru_pkg::DW - 1)) begin
                  state_ff <= S_RTRND;
               end
            end
            S_RTRND:  state_ff <= S_DVINC;
            S_DVINC: begin
               cnt_ff   <= '0;
               state_ff <= S_DVSTC;
            end
            S_DVSTC: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(gru_pkg::QW - 1)) begin
                  state_ff <= S_DVENC;
               end
            end
            S_DVENC:  state_ff <= S_DVINS;
            S_DVINS: begin
               cnt_ff   <= '0;
               state_ff <= S_DVSTS;
            end
            S_DVSTS: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(gru_pkg::QW - 1)) begin
                  state_ff <= S_DVENS;
               end
            end
            S_DVENS:  state_ff <= S_GENRES;
            S_GENRES: state_ff <= S_OUT;
            S_MCX:    state_ff <= S_ALD1;
            S_ALD1:   state_ff <= S_MSY;
            S_MSY:    state_ff <= S_AADD;
            S_AADD:   state_ff <= S_RND1;
            S_RND1:   state_ff <= S_MCY;
            S_MCY:    state_ff <= S_ALD2;
            S_ALD2:   state_ff <= S_MSX;
            S_MSX:    state_ff <= S_ASUB;
            S_ASUB:   state_ff <= S_RND2;
            S_RND2:   state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted beat not decoded");
   a_out_only_free: assert property (@(posedge clock) disable iff (reset)
      (op == gru_pkg::OP_OUT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RTSTEP) |-> (cnt_ff < CW'(gru_pkg::DW)))
      else $error("square root step count overrun");
   a_rsp_rises_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside output state");
`endif

endmodule

FILE: hdl/givens_rotation_unit.sv
// givens_rotation_unit: generate runs the bit-serial square root and the two serial divisions;
// apply runs through one shared multiplier; a zero pair on generate goes through the zero state
// to the output; one item at a time, the next beat taken in the idle cycle after the result is
// raised, even while it waits on the rsp side
// synchronous active-high reset clears the sequencer, the response valid and the rotation
// depends on gru_pkg, gru_ctrl and gru_datapath
module givens_rotation_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [gru_pkg::DW-1:0]   req_first_value,
   input  logic [gru_pkg::DW-1:0]   req_second_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [gru_pkg::DW-1:0]   rsp_first_result,
   output logic [gru_pkg::DW-1:0]   rsp_second_result
);

   gru_pkg::dp_op_type  op;
   gru_pkg::status_type status;

   gru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   gru_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .in_opcode  (req_opcode),
      .in_first   (req_first_value),
      .in_second  (req_second_value),
      .status     (status),
      .out_first  (rsp_first_result),
      .out_second (rsp_second_result)
   );

endmodule
